/* hdl/efra_pkg.sv */
`timescale 1ns / 1ps
// package for the earliest free room allocator
// transaction types, field widths and parameter defaults; no dependencies

package efra_pkg;

   // parameter defaults
   localparam int ROOMS_DEFAULT      = 16;
   localparam int COUNT_BITS_DEFAULT = 20;

   // fixed field widths
   localparam int REQ_TIME_BITS = 32;
   localparam int TIME_BITS     = 48;
   localparam int ROOM_BITS     = 4;
   localparam int CSR_BITS      = 5;

   // room count after reset
   localparam logic [CSR_BITS-1:0] CSR_RESET = 5'd16;

   // largest time a booking can reach
   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   // request transaction
   typedef struct packed {
      logic [REQ_TIME_BITS-1:0] start_time;
      logic [REQ_TIME_BITS-1:0] end_time;
   } req_type;

   // response transaction
   typedef struct packed {
      logic [ROOM_BITS-1:0] assigned_room;
      logic [TIME_BITS-1:0] actual_start;
      logic                 was_delayed;
      logic [ROOM_BITS-1:0] most_booked_room;
   } rsp_type;

endpackage

/* hdl/efra_cell.sv */
`timescale 1ns / 1ps
// one room cell: holds the room's free time and use count, folds itself into
// the search record passing by and takes the commit write; uses efra_pkg

module efra_cell #(
   parameter int IDX        = 0,
   parameter int IW         = 4,
   parameter int COUNT_BITS = efra_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [efra_pkg::CSR_BITS-1:0]          active_rooms,
   // search record from the previous cell
   input  logic                                   valid_in,
   input  logic [efra_pkg::REQ_TIME_BITS-1:0]     start_in,
   input  logic                                   found_in,
   input  logic [IW-1:0]                          free_idx_in,
   input  logic [COUNT_BITS-1:0]                  free_uses_in,
   input  logic [IW-1:0]                          min_idx_in,
   input  logic [efra_pkg::TIME_BITS-1:0]         min_time_in,
   input  logic [COUNT_BITS-1:0]                  min_uses_in,
   input  logic [IW-1:0]                          max_idx_in,
   input  logic [COUNT_BITS-1:0]                  max_uses_in,
   // search record to the next cell
   output logic                                   valid_out,
   output logic [efra_pkg::REQ_TIME_BITS-1:0]     start_out,
   output logic                                   found_out,
   output logic [IW-1:0]                          free_idx_out,
   output logic [COUNT_BITS-1:0]                  free_uses_out,
   output logic [IW-1:0]                          min_idx_out,
   output logic [efra_pkg::TIME_BITS-1:0]         min_time_out,
   output logic [COUNT_BITS-1:0]                  min_uses_out,
   output logic [IW-1:0]                          max_idx_out,
   output logic [COUNT_BITS-1:0]                  max_uses_out,
   // booking write
   input  logic                                   commit_en,
   input  logic [IW-1:0]                          commit_room,
   input  logic [efra_pkg::TIME_BITS-1:0]         commit_free_at,
   input  logic [COUNT_BITS-1:0]                  commit_uses
);

   localparam logic [IW-1:0] MY_IDX = IW'(IDX);

   logic [efra_pkg::TIME_BITS-1:0]     free_at_ff;
   logic [COUNT_BITS-1:0]              uses_ff;
   logic                               valid_ff;
   logic [efra_pkg::REQ_TIME_BITS-1:0] start_ff;
   logic                               found_ff;
   logic [IW-1:0]                      free_idx_ff;
   logic [COUNT_BITS-1:0]              free_uses_ff;
   logic [IW-1:0]                      min_idx_ff;
   logic [efra_pkg::TIME_BITS-1:0]     min_time_ff;
   logic [COUNT_BITS-1:0]              min_uses_ff;
   logic [IW-1:0]                      max_idx_ff;
   logic [COUNT_BITS-1:0]              max_uses_ff;

   logic                               act;
   logic                               take_free;
   logic                               take_min;
   logic                               take_max;
   logic                               found_in_next;
   logic [IW-1:0]                      free_idx_in_next;
   logic [COUNT_BITS-1:0]              free_uses_in_next;
   logic [IW-1:0]                      min_idx_in_next;
   logic [efra_pkg::TIME_BITS-1:0]     min_time_in_next;
   logic [COUNT_BITS-1:0]              min_uses_in_next;
   logic [IW-1:0]                      max_idx_in_next;
   logic [COUNT_BITS-1:0]              max_uses_in_next;

   // this room takes part only inside the active range
   always_comb begin
      act       = valid_in && (IDX < int'(active_rooms));
      take_free = act && !found_in &&
                  (free_at_ff <= {{(efra_pkg::TIME_BITS - efra_pkg::REQ_TIME_BITS){1'b0}},
                                  start_in});
      take_min  = act && ((IDX == 0) || (free_at_ff < min_time_in));
      take_max  = act && ((IDX == 0) || (uses_ff > max_uses_in));
   end

   // fold this room into the record
   always_comb begin
      found_in_next     = found_in || take_free;
      free_idx_in_next  = take_free ? MY_IDX : free_idx_in;
      free_uses_in_next = take_free ? uses_ff : free_uses_in;
      min_idx_in_next   = take_min ? MY_IDX : min_idx_in;
      min_time_in_next  = take_min ? free_at_ff : min_time_in;
      min_uses_in_next  = take_min ? uses_ff : min_uses_in;
      max_idx_in_next   = take_max ? MY_IDX : max_idx_in;
      max_uses_in_next  = take_max ? uses_ff : max_uses_in;
   end

   // record stage, moves on every cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      start_ff     <= start_in;
      found_ff     <= found_in_next;
      free_idx_ff  <= free_idx_in_next;
      free_uses_ff <= free_uses_in_next;
      min_idx_ff   <= min_idx_in_next;
      min_time_ff  <= min_time_in_next;
      min_uses_ff  <= min_uses_in_next;
      max_idx_ff   <= max_idx_in_next;
      max_uses_ff  <= max_uses_in_next;
   end

   // room state, written when this room is booked
   always_ff @(posedge clock) begin
      if (reset) begin
         free_at_ff <= '0;
         uses_ff    <= '0;
      end else if (commit_en && (commit_room == MY_IDX)) begin
         free_at_ff <= commit_free_at;
         uses_ff    <= commit_uses;
      end
   end

   assign valid_out     = valid_ff;
   assign start_out     = start_ff;
   assign found_out     = found_ff;
   assign free_idx_out  = free_idx_ff;
   assign free_uses_out = free_uses_ff;
   assign min_idx_out   = min_idx_ff;
   assign min_time_out  = min_time_ff;
   assign min_uses_out  = min_uses_ff;
   assign max_idx_out   = max_idx_ff;
   assign max_uses_out  = max_uses_ff;

endmodule

/* hdl/efra_finish.sv */
`timescale 1ns / 1ps
// finishing stages: choose the room from the search record, work out the
// start, the new free time and the leading room; uses efra_pkg

module efra_finish #(
   parameter int IW         = 4,
   parameter int COUNT_BITS = efra_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // search record from the last cell
   input  logic                                   valid_in,
   input  logic [efra_pkg::REQ_TIME_BITS-1:0]     start_in,
   input  logic                                   found_in,
   input  logic [IW-1:0]                          free_idx_in,
   input  logic [COUNT_BITS-1:0]                  free_uses_in,
   input  logic [IW-1:0]                          min_idx_in,
   input  logic [efra_pkg::TIME_BITS-1:0]         min_time_in,
   input  logic [COUNT_BITS-1:0]                  min_uses_in,
   input  logic [IW-1:0]                          max_idx_in,
   input  logic [COUNT_BITS-1:0]                  max_uses_in,
   input  logic [efra_pkg::REQ_TIME_BITS-1:0]     duration,
   // booking write to the cells
   output logic                                   commit_en,
   output logic [IW-1:0]                          commit_room,
   output logic [efra_pkg::TIME_BITS-1:0]         commit_free_at,
   output logic [COUNT_BITS-1:0]                  commit_uses,
   // response
   output logic                                   rsp_strobe,
   output efra_pkg::rsp_type                      rsp_data
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   logic                               dec_valid_ff;
   logic [IW-1:0]                      pick_ff;
   logic [efra_pkg::TIME_BITS-1:0]     begin_ff;
   logic                               delayed_ff;
   logic [efra_pkg::REQ_TIME_BITS-1:0] dur_ff;
   logic [COUNT_BITS-1:0]              uses_ff;
   logic [IW-1:0]                      leader_ff;

   logic [IW-1:0]                      pick_in;
   logic [efra_pkg::TIME_BITS-1:0]     begin_in;
   logic                               delayed_in;
   logic [COUNT_BITS-1:0]              old_uses;
   logic [COUNT_BITS-1:0]              uses_in;
   logic [IW-1:0]                      leader_in;
   logic [efra_pkg::TIME_BITS-1:0]     start_wide;

   logic [efra_pkg::TIME_BITS:0]       fin_sum;
   logic [efra_pkg::TIME_BITS-1:0]     fin_time;

   logic                               rsp_strobe_ff;
   efra_pkg::rsp_type                  rsp_ff;
   efra_pkg::rsp_type                  rsp_in;

   // room choice, start time and updated use count
   always_comb begin
      start_wide = {{(efra_pkg::TIME_BITS - efra_pkg::REQ_TIME_BITS){1'b0}}, start_in};
      delayed_in = !found_in;
      pick_in    = found_in ? free_idx_in : min_idx_in;
      old_uses   = found_in ? free_uses_in : min_uses_in;
      uses_in    = (old_uses == COUNT_MAX) ? old_uses : old_uses + COUNT_BITS'(1);
      if (found_in) begin
         begin_in = start_wide;
      end else begin
         begin_in = (min_time_in > start_wide) ? min_time_in : start_wide;
      end
   end

   // leading room after this booking, from the leader before it
   always_comb begin
      if (pick_in == max_idx_in) begin
         leader_in = max_idx_in;
      end else if (uses_in > max_uses_in) begin
         leader_in = pick_in;
      end else if ((uses_in == max_uses_in) && (pick_in < max_idx_in)) begin
         leader_in = pick_in;
      end else begin
         leader_in = max_idx_in;
      end
   end

   // decision stage
   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
      end else begin
         dec_valid_ff <= valid_in;
      end
      pick_ff    <= pick_in;
      begin_ff   <= begin_in;
      delayed_ff <= delayed_in;
      dur_ff     <= duration;
      uses_ff    <= uses_in;
      leader_ff  <= leader_in;
   end

   // new free time, saturated at the top of the time range
   always_comb begin
      fin_sum  = {1'b0, begin_ff} +
                 {{(efra_pkg::TIME_BITS + 1 - efra_pkg::REQ_TIME_BITS){1'b0}}, dur_ff};
      fin_time = fin_sum[efra_pkg::TIME_BITS] ? efra_pkg::TIME_MAX
                                               : fin_sum[efra_pkg::TIME_BITS-1:0];
   end

   assign commit_en      = dec_valid_ff;
   assign commit_room    = pick_ff;
   assign commit_free_at = fin_time;
   assign commit_uses    = uses_ff;

   // response transaction
   always_comb begin
      rsp_in.assigned_room    = efra_pkg::ROOM_BITS'(pick_ff);
      rsp_in.actual_start     = begin_ff;
      rsp_in.was_delayed      = delayed_ff;
      rsp_in.most_booked_room = efra_pkg::ROOM_BITS'(leader_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= dec_valid_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

/* hdl/earliest_free_room_allocator.sv */
`timescale 1ns / 1ps
// top level of the earliest free room allocator: request intake, room count
// register, chain of room cells and finishing stages; uses efra_pkg,
// efra_cell and efra_finish

// A request is taken when start is high and busy is low. Its response is on
// rsp_strobe for exactly one cycle, raised once the search record has passed
// the register of every room cell, the decision stage and the response
// register; the receiver cannot stall it. busy stays high from the accepting
// edge until the edge that raises rsp_strobe, so a new request can be taken
// in the cycle that shows the response. The search record walks the chain of
// room cells one cell per clock, through every cell whatever the room count
// register holds. The room count register may be written only while busy is
// low.

module earliest_free_room_allocator #(
   parameter int ROOMS      = efra_pkg::ROOMS_DEFAULT,
   parameter int COUNT_BITS = efra_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          start,
   output logic                          busy,
   input  efra_pkg::req_type             req_data,
   // response channel
   output logic                          rsp_strobe,
   output efra_pkg::rsp_type             rsp_data,
   // room count register
   input  logic                          csr_write_en,
   input  logic [efra_pkg::CSR_BITS-1:0] csr_write_data
);

   localparam int IW = (ROOMS > 1) ? $clog2(ROOMS) : 1;

   logic                               busy_ff;
   logic                               busy_in;
   logic [efra_pkg::CSR_BITS-1:0]      rooms_ff;
   logic [efra_pkg::CSR_BITS-1:0]      active_rooms;
   logic [efra_pkg::REQ_TIME_BITS-1:0] dur_ff;
   logic [efra_pkg::REQ_TIME_BITS-1:0] dur_in;
   logic                               accept;

   // taps between cells, tap 0 is the chain head
   logic                               tap_valid     [ROOMS+1];
   logic [efra_pkg::REQ_TIME_BITS-1:0] tap_start     [ROOMS+1];
   logic                               tap_found     [ROOMS+1];
   logic [IW-1:0]                      tap_free_idx  [ROOMS+1];
   logic [COUNT_BITS-1:0]              tap_free_uses [ROOMS+1];
   logic [IW-1:0]                      tap_min_idx   [ROOMS+1];
   logic [efra_pkg::TIME_BITS-1:0]     tap_min_time  [ROOMS+1];
   logic [COUNT_BITS-1:0]              tap_min_uses  [ROOMS+1];
   logic [IW-1:0]                      tap_max_idx   [ROOMS+1];
   logic [COUNT_BITS-1:0]              tap_max_uses  [ROOMS+1];

   logic                               commit_en;
   logic [IW-1:0]                      commit_room;
   logic [efra_pkg::TIME_BITS-1:0]     commit_free_at;
   logic [COUNT_BITS-1:0]              commit_uses;

   assign accept = start && !busy_ff;

   // room count register
   always_ff @(posedge clock) begin
      if (reset) begin
         rooms_ff <= efra_pkg::CSR_RESET;
      end else if (csr_write_en) begin
         rooms_ff <= csr_write_data;
      end
   end

   // active room count, clamped to one .. ROOMS
   always_comb begin
      if (rooms_ff == '0) begin
         active_rooms = efra_pkg::CSR_BITS'(1);
      end else if (int'(rooms_ff) > ROOMS) begin
         active_rooms = efra_pkg::CSR_BITS'(ROOMS);
      end else begin
         active_rooms = rooms_ff;
      end
   end

   // busy from accept until the booking is written back
   always_comb begin
      if (accept) begin
         busy_in = 1'b1;
      end else if (commit_en) begin
         busy_in = 1'b0;
      end else begin
         busy_in = busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;

   // duration, zero when the end is not after the start
   assign dur_in = (req_data.end_time > req_data.start_time) ?
                   (req_data.end_time - req_data.start_time) : '0;

   always_ff @(posedge clock) begin
      if (accept) begin
         dur_ff <= dur_in;
      end
   end

   // chain head: a fresh search record for the accepted transaction
   always_comb begin
      tap_valid[0]     = accept;
      tap_start[0]     = req_data.start_time;
      tap_found[0]     = 1'b0;
      tap_free_idx[0]  = '0;
      tap_free_uses[0] = '0;
      tap_min_idx[0]   = '0;
      tap_min_time[0]  = '0;
      tap_min_uses[0]  = '0;
      tap_max_idx[0]   = '0;
      tap_max_uses[0]  = '0;
   end

   // row of room cells
   for (genvar g = 0; g < ROOMS; g++) begin : g_cell
      efra_cell #(
         .IDX        (g),
         .IW         (IW),
         .COUNT_BITS (COUNT_BITS)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .active_rooms   (active_rooms),
         .valid_in       (tap_valid[g]),
         .start_in       (tap_start[g]),
         .found_in       (tap_found[g]),
         .free_idx_in    (tap_free_idx[g]),
         .free_uses_in   (tap_free_uses[g]),
         .min_idx_in     (tap_min_idx[g]),
         .min_time_in    (tap_min_time[g]),
         .min_uses_in    (tap_min_uses[g]),
         .max_idx_in     (tap_max_idx[g]),
         .max_uses_in    (tap_max_uses[g]),
         .valid_out      (tap_valid[g+1]),
         .start_out      (tap_start[g+1]),
         .found_out      (tap_found[g+1]),
         .free_idx_out   (tap_free_idx[g+1]),
         .free_uses_out  (tap_free_uses[g+1]),
         .min_idx_out    (tap_min_idx[g+1]),
         .min_time_out   (tap_min_time[g+1]),
         .min_uses_out   (tap_min_uses[g+1]),
         .max_idx_out    (tap_max_idx[g+1]),
         .max_uses_out   (tap_max_uses[g+1]),
         .commit_en      (commit_en),
         .commit_room    (commit_room),
         .commit_free_at (commit_free_at),
         .commit_uses    (commit_uses)
      );
   end

   // room choice and response
   efra_finish #(
      .IW         (IW),
      .COUNT_BITS (COUNT_BITS)
   ) u_finish (
      .clock          (clock),
      .reset          (reset),
      .valid_in       (tap_valid[ROOMS]),
      .start_in       (tap_start[ROOMS]),
      .found_in       (tap_found[ROOMS]),
      .free_idx_in    (tap_free_idx[ROOMS]),
      .free_uses_in   (tap_free_uses[ROOMS]),
      .min_idx_in     (tap_min_idx[ROOMS]),
      .min_time_in    (tap_min_time[ROOMS]),
      .min_uses_in    (tap_min_uses[ROOMS]),
      .max_idx_in     (tap_max_idx[ROOMS]),
      .max_uses_in    (tap_max_uses[ROOMS]),
      .duration       (dur_ff),
      .commit_en      (commit_en),
      .commit_room    (commit_room),
      .commit_free_at (commit_free_at),
      .commit_uses    (commit_uses),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data)
   );

endmodule
